// File: rtl/tlvfp_pkg.sv
// ---------------------------------------------------------------------------
// tlvfp_pkg
// Shared types, codes and field lengths of the TLV response frame parser.
// ---------------------------------------------------------------------------
package tlvfp_pkg;

    // Fixed value lengths of the known fields, in bytes
    localparam logic [31:0] RAND_BYTES      = 32'd16;
    localparam logic [31:0] AUTN_BYTES      = 32'd16;
    localparam logic [31:0] XRES_STAR_BYTES = 32'd16;
    localparam logic [31:0] KAUSF_BYTES     = 32'd32;
    localparam logic [31:0] SQN_MS_BYTES    = 32'd6;

    localparam int unsigned NUM_FIELDS = 5;

    // Header layout
    localparam logic [31:0] MAGIC_BYTES = 32'd4;
    localparam logic [31:0] VERSION_POS = 32'd4;
    localparam logic [31:0] TOTAL_POS   = 32'd8;
    localparam logic [31:0] HDR_BYTES   = 32'd12;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    // TLV walk phases
    localparam logic [2:0] PH_TAG_HI = 3'd0;
    localparam logic [2:0] PH_TAG_LO = 3'd1;
    localparam logic [2:0] PH_LEN_0  = 3'd2;
    localparam logic [2:0] PH_LEN_1  = 3'd3;
    localparam logic [2:0] PH_LEN_2  = 3'd4;
    localparam logic [2:0] PH_LEN_3  = 3'd5;
    localparam logic [2:0] PH_VALUE  = 3'd6;
    localparam logic [2:0] PH_HALT   = 3'd7;

    // Error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_SHORT   = 3'd1;
    localparam logic [2:0] ERR_MAGIC   = 3'd2;
    localparam logic [2:0] ERR_VERSION = 3'd3;
    localparam logic [2:0] ERR_TOTAL   = 3'd4;
    localparam logic [2:0] ERR_TRUNC   = 3'd5;
    localparam logic [2:0] ERR_FLEN    = 3'd6;
    localparam logic [2:0] ERR_OVF     = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] REG_MAGIC     = 3'd0;
    localparam logic [2:0] REG_VERSION   = 3'd1;
    localparam logic [2:0] REG_TAG_RAND  = 3'd2;
    localparam logic [2:0] REG_TAG_AUTN  = 3'd3;
    localparam logic [2:0] REG_TAG_XRES  = 3'd4;
    localparam logic [2:0] REG_TAG_KAUSF = 3'd5;
    localparam logic [2:0] REG_TAG_SQN   = 3'd6;

    // Field ids
    localparam logic [2:0] FLD_RAND  = 3'd0;
    localparam logic [2:0] FLD_AUTN  = 3'd1;
    localparam logic [2:0] FLD_XRES  = 3'd2;
    localparam logic [2:0] FLD_KAUSF = 3'd3;
    localparam logic [2:0] FLD_SQN   = 3'd4;

    typedef struct packed {
        logic [31:0]                 magic_word;
        logic [7:0]                  version_byte;
        logic [NUM_FIELDS-1:0][15:0] tag;        // indexed by field id
    } cfg_t;

    typedef struct packed {
        logic       capture_valid;
        logic [2:0] capture_field;
        logic [4:0] capture_index;
        logic [7:0] capture_byte;
        logic       frame_done;
        logic [4:0] present_mask;
        logic [2:0] error_code;
    } result_t;

    function automatic logic [31:0] field_len(input logic [2:0] fid);
        logic [31:0] len;
        len = 32'd0;
        unique case (fid)
            FLD_RAND:  len = RAND_BYTES;
            FLD_AUTN:  len = AUTN_BYTES;
            FLD_XRES:  len = XRES_STAR_BYTES;
            FLD_KAUSF: len = KAUSF_BYTES;
            FLD_SQN:   len = SQN_MS_BYTES;
            default:   len = 32'd0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/tlv_response_frame_parser.sv
// ---------------------------------------------------------------------------
// tlv_response_frame_parser
// Byte-stream parser for TLV response frames with header checks and capture.
// ---------------------------------------------------------------------------
// Path: an accepted input byte passes the input register, then the result
//   register, before its result shows on m_tvalid.
// Throughput: one byte per cycle while the sink takes results; set by the
//   state update in the parser between the two registers.
// Reset: aresetn low synchronously empties both registers, clears all frame
//   state and sets every configuration register to zero.
// ---------------------------------------------------------------------------
module tlv_response_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // Frame bytes in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_byte
    // Results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [2:0] capture_field, [7:3] capture_index,
                                    // [15:8] capture_byte, [20:16] present_mask,
                                    // [23:21] error_code
    output logic        m_tuser,    // capture_valid
    output logic        m_tlast,    // frame_done
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    tlvfp_pkg::cfg_t    cfg;
    tlvfp_pkg::result_t res_comb;
    tlvfp_pkg::result_t res_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       advance;

    // Move the held byte through the parser whenever the result register
    // is free or being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    // Take a new request while the input register is empty or empties in the same cycle.
    assign s_tready = !in_valid_reg || advance;

    tlvfp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlvfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg),
        .result    (res_comb)
    );

    // Input register: hold the byte until the parser takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result register: hold the result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.capture_valid;
    assign m_tlast  = res_reg.frame_done;
    assign m_tdata  = {res_reg.error_code, res_reg.present_mask, res_reg.capture_byte,
                       res_reg.capture_index, res_reg.capture_field};

endmodule

// File: rtl/tlvfp_cfg_regs.sv
// ---------------------------------------------------------------------------
// tlvfp_cfg_regs
// Configuration registers: magic word, version byte and the five tag numbers.
// ---------------------------------------------------------------------------
module tlvfp_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output tlvfp_pkg::cfg_t     cfg
);

    tlvfp_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tlvfp_pkg::REG_MAGIC:     cfg_reg.magic_word   <= cfg_data;
                tlvfp_pkg::REG_VERSION:   cfg_reg.version_byte <= cfg_data[7:0];
                tlvfp_pkg::REG_TAG_RAND:  cfg_reg.tag[tlvfp_pkg::FLD_RAND]  <= cfg_data[15:0];
                tlvfp_pkg::REG_TAG_AUTN:  cfg_reg.tag[tlvfp_pkg::FLD_AUTN]  <= cfg_data[15:0];
                tlvfp_pkg::REG_TAG_XRES:  cfg_reg.tag[tlvfp_pkg::FLD_XRES]  <= cfg_data[15:0];
                tlvfp_pkg::REG_TAG_KAUSF: cfg_reg.tag[tlvfp_pkg::FLD_KAUSF] <= cfg_data[15:0];
                tlvfp_pkg::REG_TAG_SQN:   cfg_reg.tag[tlvfp_pkg::FLD_SQN]   <= cfg_data[15:0];
                default: ;  // index beyond the list: drop the write
            endcase
        end
    end

endmodule

// File: rtl/tlvfp_parser.sv
// ---------------------------------------------------------------------------
// tlvfp_parser
// Per-frame parse state and the single-pass update for one byte.
// ---------------------------------------------------------------------------
module tlvfp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  tlvfp_pkg::cfg_t     cfg,
    output tlvfp_pkg::result_t  result
);

    logic [31:0] byte_count_reg,      byte_count_next;
    logic [31:0] declared_total_reg,  declared_total_next;
    logic [2:0]  header_error_reg,    header_error_next;
    logic [2:0]  tlv_phase_reg,       tlv_phase_next;
    logic [15:0] current_tag_reg,     current_tag_next;
    logic [31:0] value_remaining_reg, value_remaining_next;
    logic [4:0]  value_index_reg,     value_index_next;
    logic [2:0]  current_field_reg,   current_field_next;
    logic [4:0]  seen_mask_reg,       seen_mask_next;
    logic [2:0]  first_tlv_error_reg, first_tlv_error_next;

    logic [7:0]  magic_want;
    logic [31:0] len_new;
    logic [32:0] pos_after;
    logic [32:0] value_end;
    logic        tag_hit;
    logic [2:0]  tag_fid;
    logic [2:0]  err;

    always_comb begin
        unique case (byte_count_reg[1:0])
            2'd0:    magic_want = cfg.magic_word[31:24];
            2'd1:    magic_want = cfg.magic_word[23:16];
            2'd2:    magic_want = cfg.magic_word[15:8];
            default: magic_want = cfg.magic_word[7:0];
        endcase
    end

    // Completed TLV header: length and end position of its value
    assign len_new   = {value_remaining_reg[23:0], data_byte};
    assign pos_after = {1'b0, byte_count_reg} + 33'd1;
    assign value_end = pos_after + {1'b0, len_new};

    // Lowest field id wins on a tag clash
    always_comb begin
        tag_hit = 1'b0;
        tag_fid = 3'd0;
        for (int f = tlvfp_pkg::NUM_FIELDS - 1; f >= 0; f--) begin
            if (cfg.tag[f] == current_tag_reg) begin
                tag_hit = 1'b1;
                tag_fid = 3'(f);
            end
        end
    end

    always_comb begin
        byte_count_next      = byte_count_reg;
        declared_total_next  = declared_total_reg;
        header_error_next    = header_error_reg;
        tlv_phase_next       = tlv_phase_reg;
        current_tag_next     = current_tag_reg;
        value_remaining_next = value_remaining_reg;
        value_index_next     = value_index_reg;
        current_field_next   = current_field_reg;
        seen_mask_next       = seen_mask_reg;
        first_tlv_error_next = first_tlv_error_reg;
        result               = '0;
        err                  = tlvfp_pkg::ERR_NONE;

        if (byte_count_reg == tlvfp_pkg::COUNT_MAX) begin
            header_error_next = tlvfp_pkg::ERR_OVF;
        end else begin
            if (byte_count_reg < tlvfp_pkg::MAGIC_BYTES) begin
                if (data_byte != magic_want && header_error_reg == tlvfp_pkg::ERR_NONE)
                    header_error_next = tlvfp_pkg::ERR_MAGIC;
            end else if (byte_count_reg == tlvfp_pkg::VERSION_POS) begin
                if (data_byte != cfg.version_byte && header_error_reg == tlvfp_pkg::ERR_NONE)
                    header_error_next = tlvfp_pkg::ERR_VERSION;
            end else if (byte_count_reg >= tlvfp_pkg::TOTAL_POS &&
                         byte_count_reg < tlvfp_pkg::HDR_BYTES) begin
                declared_total_next = {declared_total_reg[23:0], data_byte};
            end else if (byte_count_reg >= tlvfp_pkg::HDR_BYTES) begin
                case (tlv_phase_reg)
                    tlvfp_pkg::PH_TAG_HI: begin
                        current_tag_next = {data_byte, 8'd0};
                        tlv_phase_next   = tlvfp_pkg::PH_TAG_LO;
                    end
                    tlvfp_pkg::PH_TAG_LO: begin
                        current_tag_next     = {current_tag_reg[15:8], data_byte};
                        value_remaining_next = 32'd0;
                        tlv_phase_next       = tlvfp_pkg::PH_LEN_0;
                    end
                    tlvfp_pkg::PH_LEN_0, tlvfp_pkg::PH_LEN_1, tlvfp_pkg::PH_LEN_2: begin
                        value_remaining_next = len_new;
                        tlv_phase_next       = tlv_phase_reg + 3'd1;
                    end
                    tlvfp_pkg::PH_LEN_3: begin
                        value_remaining_next = len_new;
                        if (value_end > {1'b0, declared_total_reg}) begin
                            first_tlv_error_next = tlvfp_pkg::ERR_TRUNC;
                            tlv_phase_next       = tlvfp_pkg::PH_HALT;
                        end else if (tag_hit) begin
                            if (len_new != tlvfp_pkg::field_len(tag_fid)) begin
                                first_tlv_error_next = tlvfp_pkg::ERR_FLEN;
                                tlv_phase_next       = tlvfp_pkg::PH_HALT;
                            end else begin
                                current_field_next = tag_fid + 3'd1;
                                value_index_next   = 5'd0;
                                tlv_phase_next     = tlvfp_pkg::PH_VALUE;
                            end
                        end else begin
                            current_field_next = 3'd0;
                            tlv_phase_next     = (len_new == 32'd0) ? tlvfp_pkg::PH_TAG_HI
                                                                    : tlvfp_pkg::PH_VALUE;
                        end
                    end
                    tlvfp_pkg::PH_VALUE: begin
                        if (current_field_reg != 3'd0 &&
                            header_error_reg == tlvfp_pkg::ERR_NONE &&
                            first_tlv_error_reg == tlvfp_pkg::ERR_NONE) begin
                            result.capture_valid = 1'b1;
                            result.capture_field = current_field_reg - 3'd1;
                            result.capture_index = value_index_reg;
                            result.capture_byte  = data_byte;
                        end
                        value_index_next     = value_index_reg + 5'd1;
                        value_remaining_next = value_remaining_reg - 32'd1;
                        if (value_remaining_reg == 32'd1) begin
                            if (current_field_reg != 3'd0)
                                seen_mask_next = seen_mask_reg |
                                                 (5'b1 << (current_field_reg - 3'd1));
                            current_field_next = 3'd0;
                            tlv_phase_next     = tlvfp_pkg::PH_TAG_HI;
                        end
                    end
                    default: ;  // halted: skip to the end of the frame
                endcase
            end
            byte_count_next = byte_count_reg + 32'd1;
        end

        if (last_byte) begin
            if (header_error_next == tlvfp_pkg::ERR_OVF)
                err = tlvfp_pkg::ERR_OVF;
            else if (byte_count_next < tlvfp_pkg::HDR_BYTES)
                err = tlvfp_pkg::ERR_SHORT;
            else if (header_error_next != tlvfp_pkg::ERR_NONE)
                err = header_error_next;
            else if (declared_total_next != byte_count_next)
                err = tlvfp_pkg::ERR_TOTAL;
            else if (first_tlv_error_next != tlvfp_pkg::ERR_NONE)
                err = first_tlv_error_next;
            else if (tlv_phase_next != tlvfp_pkg::PH_TAG_HI)
                err = tlvfp_pkg::ERR_TRUNC;
            else
                err = tlvfp_pkg::ERR_NONE;

            result.frame_done   = 1'b1;
            result.error_code   = err;
            result.present_mask = (err == tlvfp_pkg::ERR_NONE) ? seen_mask_next : 5'd0;

            // Frame over: drop all per-frame state
            byte_count_next      = 32'd0;
            declared_total_next  = 32'd0;
            header_error_next    = tlvfp_pkg::ERR_NONE;
            tlv_phase_next       = tlvfp_pkg::PH_TAG_HI;
            current_tag_next     = 16'd0;
            value_remaining_next = 32'd0;
            value_index_next     = 5'd0;
            current_field_next   = 3'd0;
            seen_mask_next       = 5'd0;
            first_tlv_error_next = tlvfp_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg      <= 32'd0;
            declared_total_reg  <= 32'd0;
            header_error_reg    <= tlvfp_pkg::ERR_NONE;
            tlv_phase_reg       <= tlvfp_pkg::PH_TAG_HI;
            current_tag_reg     <= 16'd0;
            value_remaining_reg <= 32'd0;
            value_index_reg     <= 5'd0;
            current_field_reg   <= 3'd0;
            seen_mask_reg       <= 5'd0;
            first_tlv_error_reg <= tlvfp_pkg::ERR_NONE;
        end else if (step) begin
            byte_count_reg      <= byte_count_next;
            declared_total_reg  <= declared_total_next;
            header_error_reg    <= header_error_next;
            tlv_phase_reg       <= tlv_phase_next;
            current_tag_reg     <= current_tag_next;
            value_remaining_reg <= value_remaining_next;
            value_index_reg     <= value_index_next;
            current_field_reg   <= current_field_next;
            seen_mask_reg       <= seen_mask_next;
            first_tlv_error_reg <= first_tlv_error_next;
        end
    end

endmodule

// File: rtl/tlvfp_checker.sv
// ---------------------------------------------------------------------------
// tlvfp_checker
// Port-level checks on the result stream of the TLV frame parser.
// ---------------------------------------------------------------------------
module tlvfp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Error codes appear only at the end of a frame
    a_err_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23:21] != 3'd0 |-> m_tlast)
        else $error("error code outside frame end");

    // Presence mask only on a clean frame end
    a_mask_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20:16] != 5'd0 |-> m_tlast && m_tdata[23:21] == 3'd0)
        else $error("presence mask on a failed or unfinished frame");

    // Capture fields are zero when nothing is captured
    a_capture_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[15:0] == 16'd0)
        else $error("capture fields set without a capture");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tlv_response_frame_parser tlvfp_checker u_tlvfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
